### rtl/objnx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// objnx_pkg
// Shared types and constants of the OBJ text number extractor.
// ----------------------------------------------------------------------------
package objnx_pkg;

	// Accumulator width of a float mantissa; the port shows the low MAG_OUT_BITS
	localparam int MAG_BITS     = 32;
	localparam int MAG_OUT_BITS = 32;
	localparam int FACE_BITS    = 16;

	localparam logic [3:0] MAX_DECIMALS = 4'd9;

	// Characters of interest
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;

	// Record kinds as shown on the result channel
	localparam logic [1:0] KIND_POS  = 2'd0;
	localparam logic [1:0] KIND_NRM  = 2'd1;
	localparam logic [1:0] KIND_TEX  = 2'd2;
	localparam logic [1:0] KIND_FACE = 2'd3;

	// Register indexes (byte address 4*i)
	localparam logic [1:0] REG_POS  = 2'd0;
	localparam logic [1:0] REG_NRM  = 2'd1;
	localparam logic [1:0] REG_TEX  = 2'd2;
	localparam logic [1:0] REG_FACE = 2'd3;

	localparam logic [3:0] RST_POS_VALUES  = 4'd4;
	localparam logic [3:0] RST_NRM_VALUES  = 4'd4;
	localparam logic [3:0] RST_TEX_VALUES  = 4'd2;
	localparam logic [3:0] RST_FACE_VALUES = 4'd9;

	typedef enum logic [6:0] {
		MODE_START = 7'b0000001,
		MODE_SAW_V = 7'b0000010,
		MODE_POS   = 7'b0000100,
		MODE_NRM   = 7'b0001000,
		MODE_TEX   = 7'b0010000,
		MODE_FACE  = 7'b0100000,
		MODE_SKIP  = 7'b1000000
	} line_mode_t;

endpackage : objnx_pkg
`default_nettype wire

### rtl/obj_mesh_text_number_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obj_mesh_text_number_extractor
// Pulls the decimal numbers out of v / vn / vt / f lines of OBJ text.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_ready / text_byte): one ASCII byte per
//    transaction. The byte is registered, then parsed from the input register.
//  - Output channel (out_valid / out_ready): one transaction per number, with
//    record kind, slot, record_done, sign, mantissa and fraction-digit count.
//    Bytes that end no number give no transaction.
//  - Path: the byte that terminates a number passes the input register and
//    the parse stage; the result register then drives it on out_valid.
//  - Throughput: one byte per cycle while no result stalls on out_ready, set
//    by the single parse stage (state update plus one multiply-by-ten add)
//    between the input and result registers.
//  - Stall: while a result waits on out_ready the input register still takes
//    one byte; a byte is parsed only once the result register is free.
//  - Reset: parser returns to line start, empty number, counts 4/4/2/9.
//    User writes counts over APB only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module obj_mesh_text_number_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	// number output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       record_kind,
	output logic [3:0]       slot,
	output logic             record_done,
	output logic             negative,
	output logic [objnx_pkg::MAG_OUT_BITS-1:0] magnitude,
	output logic [3:0]       decimals
);
	import objnx_pkg::*;

	// configuration
	logic [3:0] pos_values_q, nrm_values_q, tex_values_q, face_values_q;

	// input register
	logic       valid_s1;
	logic [7:0] text_byte_s1;

	// parser state
	line_mode_t          mode_q, mode_d;
	logic [MAG_BITS-1:0] acc_q, acc_d;
	logic [3:0]          dcnt_q, dcnt_d;
	logic                point_q, point_d;
	logic                minus_q, minus_d;
	logic                innum_q, innum_d;
	logic [3:0]          vtaken_q, vtaken_d;

	// result register
	logic                    out_valid_q;
	logic [1:0]              kind_q;
	logic [3:0]              slot_q;
	logic                    done_q;
	logic                    neg_q;
	logic [MAG_OUT_BITS-1:0] mag_q;
	logic [3:0]              dec_q;

	logic advance;
	logic wr_en;

	// parse stage signals
	line_mode_t          mode_eff;
	logic                float_go, face_go, emit, done;
	logic                is_digit, keep;
	logic [3:0]          dval;
	logic [MAG_BITS+3:0] mac;
	logic [FACE_BITS-1:0] face_acc;
	logic [1:0]          kind;
	logic [3:0]          count_raw, count_eff, vt_inc;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_values_q  <= RST_POS_VALUES;
			nrm_values_q  <= RST_NRM_VALUES;
			tex_values_q  <= RST_TEX_VALUES;
			face_values_q <= RST_FACE_VALUES;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_POS:  pos_values_q  <= pwdata[3:0];
				REG_NRM:  nrm_values_q  <= pwdata[3:0];
				REG_TEX:  tex_values_q  <= pwdata[3:0];
				REG_FACE: face_values_q <= pwdata[3:0];
				default:  pos_values_q  <= pos_values_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_POS:  prdata[3:0] = pos_values_q;
			REG_NRM:  prdata[3:0] = nrm_values_q;
			REG_TEX:  prdata[3:0] = tex_values_q;
			REG_FACE: prdata[3:0] = face_values_q;
			default:  prdata = '0;
		endcase
	end

	// handshakes
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1 <= text_byte;
		end
	end

	// parse stage
	assign is_digit = (text_byte_s1 >= CH_ZERO) && (text_byte_s1 <= CH_NINE);
	assign dval     = text_byte_s1[3:0];
	assign keep     = ~point_q | (dcnt_q < MAX_DECIMALS);
	// acc*10 + d, with room to see an overflow
	assign mac = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{MAG_BITS{1'b0}}, dval};
	assign face_acc = FACE_BITS'(({acc_q[FACE_BITS-1:0], 3'b000})
		+ ({1'b0, acc_q[FACE_BITS-1:0], 1'b0}) + {{(FACE_BITS-1){1'b0}}, dval});
	assign vt_inc = vtaken_q + 4'd1;

	always_comb begin
		case (mode_eff)
			MODE_NRM:  begin kind = KIND_NRM;  count_raw = nrm_values_q;  end
			MODE_TEX:  begin kind = KIND_TEX;  count_raw = tex_values_q;  end
			MODE_FACE: begin kind = KIND_FACE; count_raw = face_values_q; end
			default:   begin kind = KIND_POS;  count_raw = pos_values_q;  end
		endcase
	end
	// a zero count behaves as one
	assign count_eff = (count_raw == 4'd0) ? 4'd1 : count_raw;
	assign done      = (vt_inc == count_eff);

	always_comb begin
		mode_d   = mode_q;
		mode_eff = mode_q;
		acc_d    = acc_q;
		dcnt_d   = dcnt_q;
		point_d  = point_q;
		minus_d  = minus_q;
		innum_d  = innum_q;
		vtaken_d = vtaken_q;
		float_go = 1'b0;
		face_go  = 1'b0;
		emit     = 1'b0;

		case (mode_q)
			MODE_START: begin
				if (text_byte_s1 == CH_V) begin
					mode_d = MODE_SAW_V;
				end else if (text_byte_s1 == CH_F) begin
					mode_d = MODE_FACE;
				end else if (text_byte_s1 != CH_NL) begin
					mode_d = MODE_SKIP;
				end
			end
			MODE_SAW_V: begin
				if (text_byte_s1 == CH_N) begin
					mode_d = MODE_NRM;
				end else if (text_byte_s1 == CH_T) begin
					mode_d = MODE_TEX;
				end else begin
					// plain "v": this byte already belongs to the position record
					mode_d   = MODE_POS;
					mode_eff = MODE_POS;
					float_go = 1'b1;
				end
			end
			MODE_POS, MODE_NRM, MODE_TEX: begin
				float_go = 1'b1;
			end
			MODE_FACE: begin
				face_go = 1'b1;
			end
			MODE_SKIP: begin
				if (text_byte_s1 == CH_NL) begin
					mode_d = MODE_START;
				end
			end
			default: begin
				mode_d = MODE_START;
			end
		endcase

		if (float_go) begin
			if (is_digit) begin
				if (keep) begin
					acc_d = (|mac[MAG_BITS+3:MAG_BITS]) ? {MAG_BITS{1'b1}}
						: mac[MAG_BITS-1:0];
					if (point_q) begin
						dcnt_d = dcnt_q + 4'd1;
					end
				end
				innum_d = 1'b1;
			end else if (text_byte_s1 == CH_POINT) begin
				point_d = 1'b1;
			end else if (text_byte_s1 == CH_MINUS && !innum_q) begin
				minus_d = 1'b1;
				innum_d = 1'b1;
			end else if (innum_q) begin
				emit = 1'b1;
			end
		end

		if (face_go) begin
			if (is_digit) begin
				acc_d   = {{(MAG_BITS-FACE_BITS){1'b0}}, face_acc};
				innum_d = 1'b1;
			end else if (innum_q) begin
				emit = 1'b1;
			end
		end

		if (emit) begin
			acc_d   = '0;
			dcnt_d  = '0;
			point_d = 1'b0;
			minus_d = 1'b0;
			innum_d = 1'b0;
			if (done) begin
				vtaken_d = '0;
				mode_d   = (text_byte_s1 == CH_NL) ? MODE_START : MODE_SKIP;
			end else begin
				vtaken_d = vt_inc;
			end
		end

		// a slash that leaves the face record open starts an index, so "//" gives 0
		if (face_go && !is_digit && text_byte_s1 == CH_SLASH && (!innum_q || !done)) begin
			innum_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			acc_q    <= '0;
			dcnt_q   <= '0;
			point_q  <= 1'b0;
			minus_q  <= 1'b0;
			innum_q  <= 1'b0;
			vtaken_q <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			dcnt_q   <= dcnt_d;
			point_q  <= point_d;
			minus_q  <= minus_d;
			innum_q  <= innum_d;
			vtaken_q <= vtaken_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= kind;
			slot_q <= vtaken_q;
			done_q <= done;
			neg_q  <= (kind != KIND_FACE) & minus_q;
			mag_q  <= acc_q[MAG_OUT_BITS-1:0];
			dec_q  <= (kind != KIND_FACE) ? dcnt_q : 4'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign record_kind = kind_q;
	assign slot        = slot_q;
	assign record_done = done_q;
	assign negative    = neg_q;
	assign magnitude   = mag_q;
	assign decimals    = dec_q;

	// face indices carry no sign, no fraction and stay within 16 bits
	a_face_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_FACE |->
			!negative && decimals == 4'd0 && magnitude[MAG_OUT_BITS-1:FACE_BITS] == '0)
		else $error("face index with sign, fraction or above 16 bits");

	a_dec_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> decimals <= MAX_DECIMALS)
		else $error("fraction digit count beyond limit");

	// a completed record restarts the slot count
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && done |=> vtaken_q == 4'd0 && !innum_q)
		else $error("slot count not cleared at record end");

	// a stalled result blocks parsing of the next byte
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
		else $error("byte parsed while result stalled");

	a_emit_has_number: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |-> innum_q)
		else $error("number emitted with none pending");

endmodule : obj_mesh_text_number_extractor
`default_nettype wire
